>>> hdl/rdma_qp_round_robin_scheduler_macros.svh
// Assertion macros used by the scheduler RTL.
`ifndef RDMA_QP_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define RDMA_QP_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Clocked check, masked while reset is applied
`define RQRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define RQRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/rqrs_pkg.sv
// ----------------------------------------------------------------------------
// rqrs_pkg
// Types, codes and helpers of the queue-pair round-robin scheduler.
// ----------------------------------------------------------------------------
package rqrs_pkg;

    localparam int MaxEntries = 16;
    localparam int PrioGroups = 8;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);
    localparam int TimeW      = 63;
    localparam int GrpW       = 3;
    localparam int MaskW      = 8;

    // request codes
    localparam logic [1:0] ReqUpdate = 2'd0;
    localparam logic [1:0] ReqAppend = 2'd1;
    localparam logic [1:0] ReqSched  = 2'd2;

    // grant codes
    localparam logic [1:0] ChoiceAck  = 2'd0;
    localparam logic [1:0] ChoiceQp   = 2'd1;
    localparam logic [1:0] ChoiceNone = 2'd2;

    // status codes
    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusFull  = 2'd1;
    localparam logic [1:0] StatusRange = 2'd2;

    // configuration register indexes
    localparam logic RegAckPrio = 1'b0;

    typedef struct packed {
        logic [GrpW-1:0]  prio_group;
        logic             has_bytes;
        logic             window_blocked;
        logic             finished;
        logic             gate_open;
        logic [TimeW-1:0] ready_time;
        logic [TimeW-1:0] gate_time;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    // a group outside the configured range counts as paused
    function automatic logic group_paused(logic [GrpW-1:0] grp, logic [MaskW-1:0] mask);
        return (int'(grp) >= PrioGroups) || mask[grp];
    endfunction

endpackage

>>> hdl/rqrs_ifs.sv
// ----------------------------------------------------------------------------
// rqrs request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface rqrs_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [3:0]                  index;
    logic [2:0]                  prio_group;
    logic                        has_bytes;
    logic                        window_blocked;
    logic                        finished;
    logic                        gate_open;
    logic [rqrs_pkg::TimeW-1:0]  time_a;
    logic [rqrs_pkg::TimeW-1:0]  time_b;
    logic [7:0]                  pause_mask;
    logic                        ack_pending;

    modport source (output valid, req_type, index, prio_group, has_bytes, window_blocked,
                    finished, gate_open, time_a, time_b, pause_mask, ack_pending,
                    input ready);
    modport sink (input valid, req_type, index, prio_group, has_bytes, window_blocked,
                  finished, gate_open, time_a, time_b, pause_mask, ack_pending,
                  output ready);
endinterface

interface rqrs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  choice;
    logic [3:0]                  qp_index;
    logic [4:0]                  active_count;
    logic [rqrs_pkg::TimeW-1:0]  gate_wake_out;
    logic [1:0]                  status;

    modport source (output valid, choice, qp_index, active_count, gate_wake_out, status,
                    input ready);
    modport sink (input valid, choice, qp_index, active_count, gate_wake_out, status,
                  output ready);
endinterface

>>> hdl/rqrs_ram.sv
// ----------------------------------------------------------------------------
// rqrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rqrs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rdma_qp_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// rdma_qp_round_robin_scheduler
// Queue-pair table with ack priority, round-robin grant and compaction.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request beat: update a record, append one, or schedule.
//   o_rsp returns exactly one response beat per request.
//   The APB port holds ack_priority at byte address 0; write it while idle.
//   Update, append, ack grants and schedules on an empty table answer in the
//   cycle after acceptance. A table schedule first reduces the start index by
//   repeated subtraction, then walks the table through the single read port
//   of the record RAM, a read state and an evaluate state per record, until a
//   record is granted or all were seen, then, if a finished record was seen,
//   walks again from that record to compact the table.
//   One request is in flight at a time; i_req.ready is low until the response
//   beat has been taken, so a stalled receiver holds the block.
//   Reset clears the record count and ack_priority; record contents are only
//   read below the count and need no clearing.
// ----------------------------------------------------------------------------
`include "rdma_qp_round_robin_scheduler_macros.svh"

module rdma_qp_round_robin_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rqrs_req_if.sink    i_req,
    rqrs_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IdxW  = rqrs_pkg::IdxW;
    localparam int CntW  = rqrs_pkg::CntW;
    localparam int TimeW = rqrs_pkg::TimeW;

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_SCAN_RD, S_SCAN_EV, S_COMP_RD, S_COMP_EV
    } t_state;

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_count, n_count;
    logic [2:0]          r_ack_prio, n_ack_prio;
    logic [TimeW-1:0]    r_now, n_now;
    logic [TimeW-1:0]    r_wake, n_wake;
    logic [7:0]          r_mask, n_mask;
    logic [CntW-1:0]     r_mod, n_mod;
    logic [IdxW-1:0]     r_idx, n_idx;
    logic [CntW-1:0]     r_left, n_left;
    logic                r_granted, n_granted;
    logic [IdxW-1:0]     r_gidx, n_gidx;
    logic                r_any_fin, n_any_fin;
    logic [IdxW-1:0]     r_min_fin, n_min_fin;
    logic [CntW-1:0]     r_cmp_i, n_cmp_i;
    logic [CntW-1:0]     r_nxt, n_nxt;
    logic [IdxW-1:0]     r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_choice, n_choice;
    logic [3:0]          r_qpi, n_qpi;
    logic [TimeW-1:0]    r_wake_out, n_wake_out;
    logic [1:0]          r_status, n_status;

    logic                ram_we;
    logic [IdxW-1:0]     ram_waddr, ram_raddr;
    rqrs_pkg::t_entry    ram_wdata, ram_rdata, in_entry;
    logic                cfg_wr;
    logic                req_fire;
    logic                rd_elig, rd_ready_late, rd_wake_lower;
    logic [CntW-1:0]     idx_inc;

    rqrs_ram #(
        .Width (rqrs_pkg::EntryW),
        .Depth (rqrs_pkg::MaxEntries)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == rqrs_pkg::RegAckPrio) ? {29'd0, r_ack_prio} : 32'd0;

    // channel handshake
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.choice        = r_choice;
    assign o_rsp.qp_index      = r_qpi;
    assign o_rsp.active_count  = r_count;
    assign o_rsp.gate_wake_out = r_wake_out;
    assign o_rsp.status        = r_status;

    // pack the incoming record
    always_comb begin
        in_entry.prio_group     = i_req.prio_group;
        in_entry.has_bytes      = i_req.has_bytes;
        in_entry.window_blocked = i_req.window_blocked;
        in_entry.finished       = i_req.finished;
        in_entry.gate_open      = i_req.gate_open;
        in_entry.ready_time     = i_req.time_a;
        in_entry.gate_time      = i_req.time_b;
    end

    // classify the record read during the scan
    assign rd_elig = !rqrs_pkg::group_paused(ram_rdata.prio_group, r_mask)
                     && ram_rdata.has_bytes && !ram_rdata.window_blocked;
    assign rd_ready_late = ram_rdata.ready_time > r_now;
    assign rd_wake_lower = (ram_rdata.gate_time > r_now) && (ram_rdata.gate_time < r_wake);
    assign idx_inc       = {1'b0, r_idx} + CntW'(1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ack_prio  = r_ack_prio;
        n_now       = r_now;
        n_wake      = r_wake;
        n_mask      = r_mask;
        n_mod       = r_mod;
        n_idx       = r_idx;
        n_left      = r_left;
        n_granted   = r_granted;
        n_gidx      = r_gidx;
        n_any_fin   = r_any_fin;
        n_min_fin   = r_min_fin;
        n_cmp_i     = r_cmp_i;
        n_nxt       = r_nxt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_choice    = r_choice;
        n_qpi       = r_qpi;
        n_wake_out  = r_wake_out;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = i_req.index[IdxW-1:0];
        ram_wdata   = in_entry;
        ram_raddr   = r_idx;

        if (cfg_wr && paddr[2] == rqrs_pkg::RegAckPrio) begin
            n_ack_prio = pwdata[2:0];
        end

        // drop the response once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_choice   = rqrs_pkg::ChoiceNone;
                    n_qpi      = '0;
                    n_wake_out = '0;
                    n_status   = rqrs_pkg::StatusOk;
                    n_out_valid = 1'b1;
                    case (i_req.req_type)
                        rqrs_pkg::ReqUpdate: begin
                            if ({1'b0, i_req.index} < r_count) begin
                                ram_we = 1'b1;
                            end else begin
                                n_status = rqrs_pkg::StatusRange;
                            end
                        end
                        rqrs_pkg::ReqAppend: begin
                            if (r_count < CntW'(rqrs_pkg::MaxEntries)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IdxW-1:0];
                                n_count   = r_count + CntW'(1);
                            end else begin
                                n_status = rqrs_pkg::StatusFull;
                            end
                        end
                        rqrs_pkg::ReqSched: begin
                            n_now      = i_req.time_a;
                            n_wake     = i_req.time_b;
                            n_mask     = i_req.pause_mask;
                            n_wake_out = i_req.time_b;
                            if (!rqrs_pkg::group_paused(r_ack_prio, i_req.pause_mask)
                                && i_req.ack_pending) begin
                                n_choice = rqrs_pkg::ChoiceAck;
                            end else if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_mod       = {1'b0, i_req.index} + CntW'(1);
                                n_state     = S_MOD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // reduce the start index modulo the count
            S_MOD: begin
                if (r_mod >= r_count) begin
                    n_mod = r_mod - r_count;
                end else begin
                    n_idx     = r_mod[IdxW-1:0];
                    n_left    = r_count;
                    n_granted = 1'b0;
                    n_any_fin = 1'b0;
                    n_gidx    = '0;
                    n_min_fin = '0;
                    n_state   = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            // judge one record, advance round-robin
            S_SCAN_EV: begin
                if (rd_elig) begin
                    if (!rd_ready_late && ram_rdata.gate_open) begin
                        n_granted = 1'b1;
                        n_gidx    = r_idx;
                    end else if (!rd_ready_late && rd_wake_lower) begin
                        n_wake = ram_rdata.gate_time;
                    end
                end else if (ram_rdata.finished) begin
                    if (!r_any_fin || r_idx < r_min_fin) begin
                        n_min_fin = r_idx;
                    end
                    n_any_fin = 1'b1;
                end
                n_left = r_left - CntW'(1);
                n_idx  = (idx_inc == r_count) ? '0 : idx_inc[IdxW-1:0];
                if (n_granted || r_left == CntW'(1)) begin
                    n_wake_out = n_wake;
                    n_res      = n_gidx;
                    if (n_any_fin) begin
                        n_nxt   = {1'b0, n_min_fin};
                        n_cmp_i = {1'b0, n_min_fin} + CntW'(1);
                        n_state = S_COMP_RD;
                    end else begin
                        n_choice    = n_granted ? rqrs_pkg::ChoiceQp : rqrs_pkg::ChoiceNone;
                        n_qpi       = n_granted ? 4'(n_gidx) : 4'd0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            // compaction: fetch the next record or finish
            S_COMP_RD: begin
                ram_raddr = r_cmp_i[IdxW-1:0];
                if (r_cmp_i >= r_count) begin
                    n_count     = r_nxt;
                    n_choice    = r_granted ? rqrs_pkg::ChoiceQp : rqrs_pkg::ChoiceNone;
                    n_qpi       = r_granted ? 4'(r_res) : 4'd0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_COMP_EV;
                end
            end
            // compaction: move a live record down
            S_COMP_EV: begin
                if (!ram_rdata.finished) begin
                    if (r_granted && r_cmp_i[IdxW-1:0] == r_gidx) begin
                        n_res = r_nxt[IdxW-1:0];
                    end
                    ram_we    = 1'b1;
                    ram_waddr = r_nxt[IdxW-1:0];
                    ram_wdata = ram_rdata;
                    n_nxt     = r_nxt + CntW'(1);
                end
                n_cmp_i = r_cmp_i + CntW'(1);
                n_state = S_COMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ack_prio  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ack_prio  <= n_ack_prio;
            r_out_valid <= n_out_valid;
        end
        r_now      <= n_now;
        r_wake     <= n_wake;
        r_mask     <= n_mask;
        r_mod      <= n_mod;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_granted  <= n_granted;
        r_gidx     <= n_gidx;
        r_any_fin  <= n_any_fin;
        r_min_fin  <= n_min_fin;
        r_cmp_i    <= n_cmp_i;
        r_nxt      <= n_nxt;
        r_res      <= n_res;
        r_choice   <= n_choice;
        r_qpi      <= n_qpi;
        r_wake_out <= n_wake_out;
        r_status   <= n_status;
    end

    `RQRS_ASSERT_ALWAYS(a_count_bound, (!i_rst_n || r_count <= CntW'(rqrs_pkg::MaxEntries)), "record count beyond table size")
    `RQRS_ASSERT(a_scan_in_table, (r_state == S_SCAN_EV) |-> ({1'b0, r_idx} < r_count), "scan index outside table")
    `RQRS_ASSERT(a_compact_below, (r_state == S_COMP_EV) |-> (r_nxt < r_cmp_i), "compaction write overtakes read")

endmodule

>>> bench/rqrs_sched_board.sv
// ----------------------------------------------------------------------------
// Scheduler expectation board
// Table predictor of the queue-pair scheduler and the queue of expected
// response beats that it fills; responses are checked in order against it.
// ----------------------------------------------------------------------------
class rqrs_sched_board;
    typedef struct {
        logic [1:0]  choice;
        logic [3:0]  qp_index;
        logic [4:0]  active_count;
        logic [62:0] gate_wake_out;
        logic [1:0]  status;
    } t_answer;

    typedef struct {
        logic [2:0]  grp;
        bit          has_bytes;
        bit          win_block;
        bit          fin;
        bit          gate_open;
        logic [62:0] ready_time;
        logic [62:0] gate_time;
    } t_record;

    t_record table_q[16];
    int          used;
    logic [2:0]  ack_prio;
    t_answer     pending[$];
    int          errors;

    function new();
        used = 0;
        ack_prio = 0;
        errors = 0;
    endfunction

    function bit paused(logic [2:0] grp, logic [7:0] mask);
        return (int'(grp) >= rqrs_pkg::PrioGroups) || mask[grp];
    endfunction

    function t_record make_record(logic [2:0] g, bit hb, bit wb, bit fn, bit go,
                                  logic [62:0] ta, logic [62:0] tb);
        t_record r;
        r.grp = g; r.has_bytes = hb; r.win_block = wb; r.fin = fn; r.gate_open = go;
        r.ready_time = ta; r.gate_time = tb;
        return r;
    endfunction

    // note one accepted request beat and queue its expected response
    function void note_request(logic [1:0] req, logic [3:0] idx, t_record rec,
                               logic [62:0] ta, logic [62:0] tb,
                               logic [7:0] mask, bit ack);
        t_answer a;
        int last, k, pos, gidx, min_fin, nxt, res;
        bit granted, any_fin;
        t_record f;
        a.choice = rqrs_pkg::ChoiceNone;
        a.qp_index = 0;
        a.gate_wake_out = 0;
        a.status = rqrs_pkg::StatusOk;
        if (req == rqrs_pkg::ReqUpdate) begin
            if (idx < used) table_q[idx] = rec;
            else a.status = rqrs_pkg::StatusRange;
        end else if (req == rqrs_pkg::ReqAppend) begin
            if (used < 16) begin
                table_q[used] = rec;
                used++;
            end else begin
                a.status = rqrs_pkg::StatusFull;
            end
        end else if (req == rqrs_pkg::ReqSched) begin
            a.gate_wake_out = tb;
            if (!paused(ack_prio, mask) && ack) begin
                a.choice = rqrs_pkg::ChoiceAck;
            end else begin
                last = idx;
                granted = 0; any_fin = 0; gidx = 0; min_fin = 0;
                for (k = 1; k <= used; k++) begin
                    pos = (k + last) % used;
                    f = table_q[pos];
                    if (!paused(f.grp, mask) && f.has_bytes && !f.win_block) begin
                        if (f.ready_time > ta) continue;
                        if (!f.gate_open) begin
                            if (f.gate_time > ta && f.gate_time < a.gate_wake_out)
                                a.gate_wake_out = f.gate_time;
                            continue;
                        end
                        granted = 1;
                        gidx = pos;
                        break;
                    end else if (f.fin) begin
                        if (!any_fin || pos < min_fin) min_fin = pos;
                        any_fin = 1;
                    end
                end
                // drop finished records from the least finished index on
                if (any_fin) begin
                    nxt = min_fin;
                    res = gidx;
                    for (k = min_fin + 1; k < used; k++) begin
                        if (!table_q[k].fin) begin
                            if (granted && k == gidx) res = nxt;
                            table_q[nxt] = table_q[k];
                            nxt++;
                        end
                    end
                    used = nxt;
                    gidx = res;
                end
                if (granted) begin
                    a.choice = rqrs_pkg::ChoiceQp;
                    a.qp_index = gidx[3:0];
                end
            end
        end
        a.active_count = used[4:0];
        pending.push_back(a);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endfunction

    // compare one response beat with the oldest expectation
    function void check_response(logic [1:0] ch, logic [3:0] qi, logic [4:0] cnt,
                                 logic [62:0] wake, logic [1:0] st);
        t_answer a;
        if (pending.size() == 0) begin
            errors++;
            $display("mismatch: response beat with nothing expected");
            return;
        end
        a = pending.pop_front();
        if (ch !== a.choice) report("choice", ch, a.choice);
        if (qi !== a.qp_index) report("qp_index", qi, a.qp_index);
        if (cnt !== a.active_count) report("active_count", cnt, a.active_count);
        if (wake !== a.gate_wake_out) report("gate_wake_out", wake, a.gate_wake_out);
        if (st !== a.status) report("status", st, a.status);
    endfunction
endclass

>>> bench/rdma_qp_round_robin_scheduler_test.sv
// ----------------------------------------------------------------------------
// Queue-pair scheduler test
// Drives directed and random table traffic with random gaps and stalls, and
// checks every response beat against an in-order prediction.
// ----------------------------------------------------------------------------
module rdma_qp_round_robin_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rqrs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          cycles;
    bit          sink_on;

    rqrs_req_if req_ch();
    rqrs_rsp_if rsp_ch();
    rqrs_sched_board board;

    rdma_qp_round_robin_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // take response beats with random stalls
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.choice, rsp_ch.qp_index, rsp_ch.active_count,
                                 rsp_ch.gate_wake_out, rsp_ch.status);
    end

    initial begin
        int w;
        forever begin
            @(posedge i_clk);
            if (!sink_on) continue;
            if (rsp_ch.ready && !rsp_ch.valid) continue;
            if (rsp_ch.ready && rsp_ch.valid) begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if (w > 0) begin
                    rsp_ch.ready <= 0;
                    repeat (w) @(posedge i_clk);
                    rsp_ch.ready <= 1;
                end
            end else begin
                rsp_ch.ready <= 1;
            end
        end
    end

    task automatic write_ack_prio(logic [2:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= {29'd0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.ack_prio = v;
    endtask

    // withdraw the request beat and wait for every response
    task automatic quiesce();
        req_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // wait for the table to drain before a register write
    task automatic drain();
        quiesce();
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send(logic [1:0] rt, logic [3:0] idx, logic [2:0] g, bit hb, bit wb,
                        bit fn, bit go, logic [62:0] ta, logic [62:0] tb,
                        logic [7:0] mask, bit ack);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        // hold off between beats, or follow straight on
        if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1; req_ch.req_type <= rt; req_ch.index <= idx;
        req_ch.prio_group <= g; req_ch.has_bytes <= hb; req_ch.window_blocked <= wb;
        req_ch.finished <= fn; req_ch.gate_open <= go; req_ch.time_a <= ta;
        req_ch.time_b <= tb; req_ch.pause_mask <= mask; req_ch.ack_pending <= ack;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(rt, idx, board.make_record(g, hb, wb, fn, go, ta, tb),
                           ta, tb, mask, ack);
    endtask

    function automatic logic [62:0] rnd_time();
        case ($urandom_range(0, 3))
            0: return 63'({$urandom, $urandom});
            1: return 63'h7fff_ffff_ffff_ffff;
            default: return 63'($urandom_range(0, 200));
        endcase
    endfunction

    // random item: mostly well-formed table traffic with small times
    task automatic random_item();
        int r;
        logic [1:0] rt;
        logic [3:0] idx;
        r = $urandom_range(0, 99);
        if (r < 30) rt = ReqAppend;
        else if (r < 50) rt = ReqUpdate;
        else if (r < 97) rt = ReqSched;
        else rt = 2'd3;
        if (rt == ReqUpdate && board.used > 0 && $urandom_range(0, 7) != 0)
            idx = 4'($urandom_range(0, board.used - 1));
        else
            idx = 4'($urandom);
        send(rt, idx, 3'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
             $urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0,
             rnd_time(), rnd_time(), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
             $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int i;
        board = new();
        cycles = 0;
        sink_on = 0;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req_ch.valid = 0; req_ch.req_type = 0; req_ch.index = 0; req_ch.prio_group = 0;
        req_ch.has_bytes = 0; req_ch.window_blocked = 0; req_ch.finished = 0;
        req_ch.gate_open = 0; req_ch.time_a = 0; req_ch.time_b = 0;
        req_ch.pause_mask = 0; req_ch.ack_pending = 0;
        rsp_ch.ready = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        sink_on = 1;

        // directed: empty table, range and full errors, extremes, compaction
        write_ack_prio(3'd7);
        send(ReqSched, 4'hf, 0, 0, 0, 0, 0, 0, '1, 8'h00, 1);
        send(ReqSched, 4'h0, 0, 0, 0, 0, 0, 5, 9, 8'h80, 1);
        send(ReqUpdate, 4'h0, 7, 1, 1, 1, 1, '1, '1, 8'hff, 1);
        send(2'd3, 4'hf, 7, 1, 1, 1, 1, '1, '1, 8'hff, 1);
        for (i = 0; i < 16; i++)
            send(ReqAppend, 0, i[2:0], 1, i == 3, i % 5 == 4, i != 6,
                 (i == 9) ? 63'h7fff_ffff_ffff_ffff : 63'(i), 63'(50 + i), 8'h00, 0);
        send(ReqAppend, 0, 0, 1, 0, 0, 1, 0, 0, 8'h00, 0);
        send(ReqUpdate, 4'hf, 2, 1, 0, 1, 1, 0, 0, 8'h00, 0);
        send(ReqSched, 4'h2, 0, 0, 0, 0, 0, 20, '1, 8'h01, 0);
        send(ReqSched, 4'hf, 0, 0, 0, 0, 0, 0, '1, 8'hff, 1);
        send(ReqSched, 4'h5, 0, 0, 0, 0, 0, '1, '1, 8'h00, 0);
        drain();
        write_ack_prio(3'd0);

        for (i = 0; i < 1150; i++) begin
            random_item();
            if (i == 400 || i == 800) begin
                drain();
                write_ack_prio((i == 400) ? 3'd3 : 3'($urandom));
            end
            if (i == 600) quiesce();
        end

        quiesce();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
